[src/utf8e_pkg.sv]
// ----------------------------------------------------------------------------
// utf8e_pkg
// Shared types, codes and helpers for the UTF-32 to UTF-8 encoder.
// ----------------------------------------------------------------------------
package utf8e_pkg;

    // width of the per-buffer item counter (8 to 64)
    localparam int INDEX_BITS  = 32;
    // entries in the queue between front and back, power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_PRECISE = 2'd1;
    localparam logic [1:0] MODE_AT_END  = 2'd2;
    localparam logic [1:0] MODE_RESET   = MODE_PRECISE;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SURROGATE = 2'd1;
    localparam logic [1:0] ST_ABOVE_MAX = 2'd2;

    localparam logic [31:0] MAX_CODE_POINT = 32'h0010_FFFF;

    // one queued job: all results of one accepted word
    typedef struct packed {
        logic [3:0][7:0]  bytes;      // byte k in bytes[k]
        logic [1:0]       last_idx;   // number of results minus one
        logic             byte_valid; // 0 for a status-only result
        logic [1:0]       status;     // applies to the last result only
        logic [31:0]      index;
        logic             done;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } push_t;

    function automatic logic [31:0] index_word(input logic [INDEX_BITS-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[31:0];
    endfunction

endpackage

[src/utf8e_front.sv]
// ----------------------------------------------------------------------------
// utf8e_front
// Accepts code points, tracks buffer state and builds at most one job per word.
// ----------------------------------------------------------------------------
module utf8e_front
    import utf8e_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  s_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_data,
    input  logic                  queue_full,
    output push_t                 push_out
);

    logic [1:0]            error_mode_reg, error_mode_next;
    logic [INDEX_BITS-1:0] item_count_reg, item_count_next;
    logic                  stopped_reg, stopped_next;
    logic [1:0]            stop_status_reg, stop_status_next;
    logic                  surrogate_seen_reg, surrogate_seen_next;

    logic                  accept;
    logic [31:0]           w;
    logic                  fits1, fits2, fits3;
    logic                  is_surr, above_max, checking, at_end;
    logic                  stop_now;
    logic [1:0]            stop_code;
    logic                  surr_flag;
    logic [INDEX_BITS-1:0] count_inc;
    logic [3:0][7:0]       enc;
    logic [1:0]            enc_last;

    assign s_tready  = !queue_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign w         = s_tdata;

    assign fits1     = (w[31:7] == '0);
    assign fits2     = (w[31:11] == '0);
    assign fits3     = (w[31:16] == '0);
    // 0xD800 to 0xDFFF
    assign is_surr   = fits3 && (w[15:11] == 5'b11011);
    assign above_max = (w > MAX_CODE_POINT);
    assign checking  = (error_mode_reg != MODE_NONE);
    assign at_end    = (error_mode_reg == MODE_AT_END);

    always_comb begin
        stop_now  = 1'b0;
        stop_code = ST_OK;
        if (checking && is_surr && !at_end) begin
            stop_now  = 1'b1;
            stop_code = ST_SURROGATE;
        end else if (checking && above_max) begin
            stop_now  = 1'b1;
            stop_code = ST_ABOVE_MAX;
        end
    end

    assign surr_flag = surrogate_seen_reg || (is_surr && at_end);
    assign count_inc = item_count_reg + INDEX_BITS'(1);

    always_comb begin
        enc = '0;
        if (fits1) begin
            enc[0]   = w[7:0];
            enc_last = 2'd0;
        end else if (fits2) begin
            enc[0]   = {3'b110, w[10:6]};
            enc[1]   = {2'b10, w[5:0]};
            enc_last = 2'd1;
        end else if (fits3) begin
            enc[0]   = {4'b1110, w[15:12]};
            enc[1]   = {2'b10, w[11:6]};
            enc[2]   = {2'b10, w[5:0]};
            enc_last = 2'd2;
        end else begin
            // bits above the four-byte form fold into the lead byte
            enc[0]   = w[25:18] | 8'hF0;
            enc[1]   = {2'b10, w[17:12]};
            enc[2]   = {2'b10, w[11:6]};
            enc[3]   = {2'b10, w[5:0]};
            enc_last = 2'd3;
        end
    end

    always_comb begin
        error_mode_next     = cfg_valid ? cfg_data : error_mode_reg;
        item_count_next     = item_count_reg;
        stopped_next        = stopped_reg;
        stop_status_next    = stop_status_reg;
        surrogate_seen_next = surrogate_seen_reg;
        push_out            = '0;

        if (accept) begin
            if (stopped_reg) begin
                if (s_tlast) begin
                    push_out.push           = 1'b1;
                    push_out.job.status     = stop_status_reg;
                    push_out.job.index      = index_word(item_count_reg);
                    push_out.job.done       = 1'b1;
                end
            end else if (stop_now) begin
                push_out.push           = 1'b1;
                push_out.job.status     = stop_code;
                push_out.job.index      = index_word(item_count_reg);
                push_out.job.done       = 1'b1;
                stopped_next            = 1'b1;
                stop_status_next        = stop_code;
            end else begin
                push_out.push           = 1'b1;
                push_out.job.bytes      = enc;
                push_out.job.last_idx   = enc_last;
                push_out.job.byte_valid = 1'b1;
                push_out.job.done       = s_tlast;
                if (s_tlast) begin
                    push_out.job.status = surr_flag ? ST_SURROGATE : ST_OK;
                    push_out.job.index  = index_word(count_inc);
                end
                item_count_next         = count_inc;
                surrogate_seen_next     = surr_flag;
            end

            if (s_tlast) begin
                item_count_next     = '0;
                stopped_next        = 1'b0;
                stop_status_next    = ST_OK;
                surrogate_seen_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_mode_reg     <= MODE_RESET;
            item_count_reg     <= '0;
            stopped_reg        <= 1'b0;
            stop_status_reg    <= ST_OK;
            surrogate_seen_reg <= 1'b0;
        end else begin
            error_mode_reg     <= error_mode_next;
            item_count_reg     <= item_count_next;
            stopped_reg        <= stopped_next;
            stop_status_reg    <= stop_status_next;
            surrogate_seen_reg <= surrogate_seen_next;
        end
    end

endmodule

[src/utf8e_queue.sv]
// ----------------------------------------------------------------------------
// utf8e_queue
// Short job queue that decouples the front from the byte emitter.
// ----------------------------------------------------------------------------
module utf8e_queue
    import utf8e_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push_in,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output job_t  head_job
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];
    assign do_push    = push_in.push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        // pointers wrap on their own since the depth is a power of two
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_in.job;
        end
    end

endmodule

[src/utf8e_back.sv]
// ----------------------------------------------------------------------------
// utf8e_back
// Walks each queued job and drives one result word per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module utf8e_back
    import utf8e_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   head_valid,
    input  job_t                   head_job,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    output logic                   m_tuser
);

    logic [1:0]  pos_reg, pos_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        bvalid_reg, bvalid_next;
    logic        last_reg, last_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] index_reg, index_next;
    logic        done_reg, done_next;

    logic        load;
    logic        at_last;

    assign load    = head_valid && (!valid_reg || m_tready);
    assign at_last = (pos_reg == head_job.last_idx);
    assign pop     = load && at_last;

    always_comb begin
        pos_next    = pos_reg;
        valid_next  = valid_reg && !m_tready;
        byte_next   = byte_reg;
        bvalid_next = bvalid_reg;
        last_next   = last_reg;
        status_next = status_reg;
        index_next  = index_reg;
        done_next   = done_reg;
        if (load) begin
            valid_next  = 1'b1;
            pos_next    = at_last ? 2'd0 : pos_reg + 2'd1;
            byte_next   = head_job.bytes[pos_reg];
            bvalid_next = head_job.byte_valid;
            last_next   = at_last;
            // buffer status rides on the final word of the job only
            status_next = at_last ? head_job.status : ST_OK;
            index_next  = at_last ? head_job.index : '0;
            done_next   = at_last && head_job.done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        bvalid_reg <= bvalid_next;
        last_reg   <= last_next;
        status_reg <= status_next;
        index_reg  <= index_next;
        done_reg   <= done_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = bvalid_reg;
    assign m_tdata  = {5'd0, done_reg, index_reg, status_reg, byte_reg};

    // a status-only word always closes its job
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !bvalid_reg) |-> last_reg)
        else $error("status-only word not marked last");

    // buffer report only on the last word of a job
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && done_reg) |-> last_reg)
        else $error("buffer done on a non-final word");

    // status and index are zero unless the buffer is reported
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !done_reg) |-> (status_reg == ST_OK && index_reg == '0))
        else $error("status or index set without buffer done");

    // the walk stays inside the current job
    assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> (pos_reg <= head_job.last_idx))
        else $error("byte position past end of job");

endmodule

[src/utf32_to_utf8_encoder_top.sv]
// ----------------------------------------------------------------------------
// utf32_to_utf8_encoder_top
// UTF-32 to UTF-8 encoder with selectable error checking.
// ----------------------------------------------------------------------------
// One code point is taken per word on the s_ side, and s_tlast marks the last
// code point of a buffer. The front takes a word in every cycle while its
// four-entry job queue has room; the back emits one result word per cycle
// while m_tready is high, so a code point yields 1 to 4 result words (its
// UTF-8 length, or one status-only word), and the byte emitter sets the
// sustained rate. A stopped buffer swallows words until its final one, which
// yields a single status word. error_mode is written through the cfg port
// (0 none, 1 precise, 2 surrogates reported at buffer end); the user must
// write it only while the block is idle (not enforced); it resets to precise.
// ----------------------------------------------------------------------------
module utf32_to_utf8_encoder_top
    import utf8e_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] code_point
    input  logic                   s_tlast,   // end_of_buffer
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_data,  // error_mode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] data_byte, [9:8] status, [41:10] error_index, [42] buffer_done
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,   // last_of_run
    output logic                   m_tuser    // byte_valid
);

    push_t push;
    logic  queue_full;
    logic  pop;
    logic  head_valid;
    job_t  head_job;

    utf8e_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push_out   (push)
    );

    utf8e_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_in    (push),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    utf8e_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

[dv/utf8e_checker.sv]
// ----------------------------------------------------------------------------
// utf8e_checker
// Scoreboard for the UTF-32 to UTF-8 encoder: it watches the config, input
// and result channels, keeps its own copy of the buffer state, predicts the
// UTF-8 words of every accepted code point and compares each result word,
// field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module utf8e_checker
    import utf8e_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tlast,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [1:0]             cfg_data,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   m_tlast,
    input  logic                   m_tuser,
    output int unsigned            mismatches,
    output int unsigned            outstanding
);

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        last_of_run;
        logic [1:0]  status;
        logic [31:0] error_index;
        logic        buffer_done;
    } utf8_word_t;

    utf8_word_t             utf8_expect_q[$];
    logic [1:0]             error_mode;
    logic [INDEX_BITS-1:0]  buf_count;
    logic                   halted;
    logic [1:0]             halt_status;
    logic                   surrogate_flag;
    int unsigned            mismatch_cnt = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_cnt++;
    endtask

    task automatic push_word(input logic [7:0] b, input logic valid, input logic last,
                             input logic [1:0] st, input logic [31:0] idx,
                             input logic done);
        utf8_word_t w;
        w.data_byte   = b;
        w.byte_valid  = valid;
        w.last_of_run = last;
        w.status      = st;
        w.error_index = idx;
        w.buffer_done = done;
        utf8_expect_q.push_back(w);
    endtask

    task automatic clear_buffer_state();
        buf_count      = '0;
        halted         = 1'b0;
        halt_status    = ST_OK;
        surrogate_flag = 1'b0;
    endtask

    task automatic encode_code_point(input logic [31:0] cp, input logic eob);
        logic [7:0] seq [4];
        int         n;
        // a stopped buffer swallows words until its final one
        if (halted) begin
            if (eob) begin
                push_word(8'h00, 1'b0, 1'b1, halt_status, 32'(buf_count), 1'b1);
                clear_buffer_state();
            end
            return;
        end
        if (cp[31:7] == '0) begin
            seq[0] = cp[7:0];
            n = 1;
        end else if (cp[31:11] == '0) begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
            n = 2;
        end else if (cp[31:16] == '0) begin
            if (cp >= 32'hD800 && cp <= 32'hDFFF && error_mode != MODE_NONE) begin
                if (error_mode == MODE_AT_END) begin
                    surrogate_flag = 1'b1;
                end else begin
                    halted      = 1'b1;
                    halt_status = ST_SURROGATE;
                end
            end
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
            n = 3;
        end else begin
            if (cp > MAX_CODE_POINT && error_mode != MODE_NONE) begin
                halted      = 1'b1;
                halt_status = ST_ABOVE_MAX;
            end
            // bits above the four-byte form fold into the lead byte
            seq[0] = 8'hF0 | cp[25:18];
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
            n = 4;
        end
        if (halted) begin
            push_word(8'h00, 1'b0, 1'b1, halt_status, 32'(buf_count), 1'b1);
            if (eob) begin
                clear_buffer_state();
            end
            return;
        end
        buf_count = buf_count + INDEX_BITS'(1);
        for (int k = 0; k < n; k++) begin
            if (k == n - 1 && eob) begin
                push_word(seq[k], 1'b1, 1'b1, surrogate_flag ? ST_SURROGATE : ST_OK,
                          32'(buf_count), 1'b1);
            end else begin
                push_word(seq[k], 1'b1, k == n - 1, ST_OK, 32'h0, 1'b0);
            end
        end
        if (eob) begin
            clear_buffer_state();
        end
    endtask

    always @(posedge aclk) begin : monitor
        utf8_word_t got;
        utf8_word_t want;
        string      diff;
        if (!aresetn) begin
            error_mode = MODE_RESET;
            clear_buffer_state();
            utf8_expect_q.delete();
        end else begin
            // compare before predicting: a word cannot leave in its own accept cycle
            if (m_tvalid && m_tready) begin
                got.data_byte   = m_tdata[7:0];
                got.status      = m_tdata[9:8];
                got.error_index = m_tdata[41:10];
                got.buffer_done = m_tdata[42];
                got.last_of_run = m_tlast;
                got.byte_valid  = m_tuser;
                if (utf8_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word byte=%02h tdata=%012h",
                                              got.data_byte, m_tdata));
                end else begin
                    want = utf8_expect_q.pop_front();
                    diff = "";
                    if (got.data_byte !== want.data_byte)     diff = {diff, " data_byte"};
                    if (got.byte_valid !== want.byte_valid)   diff = {diff, " byte_valid"};
                    if (got.last_of_run !== want.last_of_run) diff = {diff, " last_of_run"};
                    if (got.status !== want.status)           diff = {diff, " status"};
                    if (got.error_index !== want.error_index) diff = {diff, " error_index"};
                    if (got.buffer_done !== want.buffer_done) diff = {diff, " buffer_done"};
                    if (diff != "") begin
                        report_mismatch({
                            $sformatf("%s | got b=%02h v=%0b l=%0b s=%0d i=%0d d=%0b",
                                      diff, got.data_byte, got.byte_valid,
                                      got.last_of_run, got.status, got.error_index,
                                      got.buffer_done),
                            $sformatf(" | want b=%02h v=%0b l=%0b s=%0d i=%0d d=%0b",
                                      want.data_byte, want.byte_valid,
                                      want.last_of_run, want.status, want.error_index,
                                      want.buffer_done)});
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                error_mode = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                encode_code_point(s_tdata[31:0], s_tlast);
            end
        end
        mismatches  <= mismatch_cnt;
        outstanding <= utf8_expect_q.size();
    end

endmodule

[dv/utf32_to_utf8_encoder_top_test.sv]
// ----------------------------------------------------------------------------
// utf32_to_utf8_encoder_top_test
// Drives code points and error-mode writes into the encoder: a directed pass
// over the range boundaries, surrogates, too-large values and every mode,
// then random buffers over several modes with bursty input and a stalling
// receiver. The checker scores every result word.
// ----------------------------------------------------------------------------
module utf32_to_utf8_encoder_top_test;
    import utf8e_pkg::*;

    localparam int         RUN_LIMIT      = 400000;
    localparam int         SETTLE_CYCLES  = 16;
    localparam int         RANDOM_WORDS   = 380;
    localparam int         PHASES         = 8;
    // the unused mode code, expected to act as precise
    localparam logic [1:0] MODE_SPARE     = 2'd3;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [1:0]             cfg_data  = MODE_NONE;
    logic                   m_tready  = 1'b0;
    logic                   s_tready;
    logic                   cfg_ready;
    logic                   m_tvalid;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    int unsigned            mismatches;
    int unsigned            outstanding;
    int unsigned            cycle_count = 0;
    int                     burst_left  = 4;
    int                     stall_style = 0;
    int                     style_left  = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    utf32_to_utf8_encoder_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    utf8e_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver back-pressure, switching between styles every so often
    always @(posedge aclk) begin
        if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(20, 150);
        end else begin
            style_left = style_left - 1;
        end
        case (stall_style)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= ($urandom_range(0, 5) == 0);
            default: m_tready <= ~m_tready;
        endcase
    end

    task automatic send_code_point(input logic [31:0] cp, input logic eob);
        s_tvalid <= 1'b1;
        s_tdata  <= cp;
        s_tlast  <= eob;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
    endtask

    // hold input until every predicted word has drained, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_error_mode(input logic [1:0] mode);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_code_point();
        logic [31:0] edges [14] = '{32'h0, 32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hD7FF,
                                     32'hD800, 32'hDFFF, 32'hE000, 32'hFFFF, 32'h10000,
                                     32'h10FFFF, 32'h110000, 32'hFFFFFFFF};
        int          sel;
        sel = $urandom_range(0, 39);
        if (sel < 12)       return $urandom_range(0, 32'h7F);
        else if (sel < 20)  return $urandom_range(32'h80, 32'h7FF);
        else if (sel < 28)  return $urandom_range(32'h800, 32'hFFFF);
        else if (sel < 34)  return $urandom_range(32'h10000, 32'h10FFFF);
        else if (sel == 34) return $urandom_range(32'hD800, 32'hDFFF);
        else if (sel == 35) return $urandom_range(32'h110000, 32'hFFFFFFFF);
        else if (sel == 36) return $urandom();
        else                return edges[$urandom_range(0, 13)];
    endfunction

    initial begin
        logic [1:0] phase_mode;
        int         per_phase;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset mode is precise: range boundaries and a clean buffer end
        send_code_point(32'h0, 1'b0);
        send_code_point(32'h7F, 1'b0);
        send_code_point(32'h80, 1'b0);
        send_code_point(32'h7FF, 1'b0);
        send_code_point(32'h800, 1'b0);
        send_code_point(32'hFFFF, 1'b0);
        send_code_point(32'h10000, 1'b0);
        send_code_point(32'h10FFFF, 1'b1);
        // surrogate stop, swallowed word, status word on buffer end
        send_code_point(32'hD7FF, 1'b0);
        send_code_point(32'hD800, 1'b0);
        send_code_point(32'h41, 1'b0);
        send_code_point(32'hE000, 1'b1);
        // too large on the final word
        send_code_point(32'h110000, 1'b1);

        write_error_mode(MODE_AT_END);
        send_code_point(32'hDFFF, 1'b0);
        send_code_point(32'h20, 1'b0);
        send_code_point(32'hFFFFFFFF, 1'b0);
        send_code_point(32'h5, 1'b1);
        send_code_point(32'hDABC, 1'b0);
        send_code_point(32'h61, 1'b1);

        // no checking: high bits fold into the lead byte
        write_error_mode(MODE_NONE);
        send_code_point(32'hFFFFFFFF, 1'b0);
        send_code_point(32'h80000000, 1'b0);
        send_code_point(32'hD800, 1'b0);
        send_code_point(32'h7FFFFFFF, 1'b1);

        write_error_mode(MODE_SPARE);
        send_code_point(32'hD900, 1'b1);
        send_code_point(32'h1, 1'b0);
        send_code_point(32'h7FFFFFFF, 1'b1);

        // random buffers; phases may split a buffer so modes also change mid-buffer
        per_phase = RANDOM_WORDS / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: phase_mode = MODE_NONE;
                1: phase_mode = MODE_AT_END;
                2: phase_mode = MODE_SPARE;
                3: phase_mode = MODE_PRECISE;
                default: phase_mode = 2'($urandom_range(0, 3));
            endcase
            write_error_mode(phase_mode);
            for (int i = 0; i < per_phase; i++) begin
                send_code_point(pick_code_point(), $urandom_range(0, 5) == 0);
            end
        end

        wait_idle();
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
